@@ hw/rtl/dipeptide_pair_histogram_assert.svh @@
// Assertion macros used by the dipeptide pair histogram checker.
`ifndef DIPEPTIDE_PAIR_HISTOGRAM_ASSERT_SVH
`define DIPEPTIDE_PAIR_HISTOGRAM_ASSERT_SVH

// The consequent must hold at the same clock edge as the antecedent.
`define DPH_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold at the clock edge after the antecedent.
`define DPH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/dph_pkg.sv @@
// Package with the types, constants and letter decoding of the dipeptide pair histogram.
`default_nettype none

package dph_pkg;

  localparam int ALPHABET           = 20;
  localparam int NUM_BINS           = ALPHABET * ALPHABET;
  localparam int BIN_BITS           = $clog2(NUM_BINS);
  localparam int CODE_BITS          = $clog2(ALPHABET);
  localparam int FUNC_BITS          = 2;
  localparam int RESIDUE_BITS       = 8;
  localparam int PAIR_COUNT_BITS    = 16;
  localparam int COUNT_BITS_DEFAULT = 16;

  localparam logic [RESIDUE_BITS-1:0] ASCII_A = 8'd65;
  localparam logic [RESIDUE_BITS-1:0] ASCII_Y = 8'd89;

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_RESIDUE = 2'd0,
    FUNC_READ    = 2'd1,
    FUNC_START   = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    OP_INC,
    OP_READ,
    OP_READ_OOR
  } bin_op_t;

  function automatic logic [CODE_BITS-1:0] letter_code(input logic [RESIDUE_BITS-1:0] ch);
    logic [CODE_BITS-1:0] code;
    code = '0;
    if (ch inside {[ASCII_A:ASCII_Y]}) begin
      case (ch)
        "C":     code = 5'd1;
        "D":     code = 5'd2;
        "E":     code = 5'd3;
        "F":     code = 5'd4;
        "G":     code = 5'd5;
        "H":     code = 5'd6;
        "I":     code = 5'd7;
        "K":     code = 5'd8;
        "L":     code = 5'd9;
        "M":     code = 5'd10;
        "N":     code = 5'd11;
        "P":     code = 5'd12;
        "Q":     code = 5'd13;
        "R":     code = 5'd14;
        "S":     code = 5'd15;
        "T":     code = 5'd16;
        "V":     code = 5'd17;
        "W":     code = 5'd18;
        "Y":     code = 5'd19;
        default: code = 5'd0;
      endcase
    end
    return code;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dph_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module dph_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 400
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/dipeptide_pair_histogram.sv @@
// A read transaction's count passes from the bin read-modify-write stage into the output register.
// Throughput: one transaction per cycle, set by the single bin read-modify-write stage.
// A read waits in that stage only while the output register is full and stalled.
// Reset is synchronous, active low; afterwards a pass over the 400 bins clears the memory
// one entry per cycle while in_stall stays high.
// Top level of the dipeptide pair histogram.
`default_nettype none

module dipeptide_pair_histogram #(
  parameter int COUNT_BITS = dph_pkg::COUNT_BITS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [dph_pkg::FUNC_BITS-1:0]       in_func,
  input  wire logic [dph_pkg::RESIDUE_BITS-1:0]    in_residue,
  input  wire logic [dph_pkg::BIN_BITS-1:0]        in_bin_index,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic      [dph_pkg::PAIR_COUNT_BITS-1:0] out_pair_count
);

  import dph_pkg::*;

  localparam int EXT_BITS = (COUNT_BITS > PAIR_COUNT_BITS) ? COUNT_BITS : PAIR_COUNT_BITS;

  logic                       clearing_r, clearing_nxt;
  logic [BIN_BITS-1:0]        clr_addr_r, clr_addr_nxt;
  logic [CODE_BITS-1:0]       prev_code_r, prev_code_nxt;
  logic                       have_prev_r, have_prev_nxt;
  logic                       s1_valid_r, s1_valid_nxt;
  bin_op_t                    s1_op_r, s1_op_nxt;
  logic [BIN_BITS-1:0]        s1_addr_r, s1_addr_nxt;
  logic                       fwd_valid_r, fwd_valid_nxt;
  logic [BIN_BITS-1:0]        fwd_addr_r, fwd_addr_nxt;
  logic [COUNT_BITS-1:0]      fwd_data_r, fwd_data_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [PAIR_COUNT_BITS-1:0] out_count_r, out_count_nxt;

  logic                  in_accept;
  logic                  s1_busy;
  logic                  s1_fire;
  logic                  s1_we;
  logic [COUNT_BITS-1:0] s1_wdata;
  logic [COUNT_BITS-1:0] cur_count;
  logic [EXT_BITS-1:0]   cur_ext;
  logic [CODE_BITS-1:0]  in_code;
  logic [BIN_BITS-1:0]   pair_addr;
  logic                  rd_en;
  logic [BIN_BITS-1:0]   rd_addr;
  logic [COUNT_BITS-1:0] rd_data;
  logic                  ram_we;
  logic [BIN_BITS-1:0]   ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;

  assign s1_busy   = s1_valid_r && (s1_op_r != OP_INC) && out_valid_r && out_stall;
  assign in_stall  = clearing_r || s1_busy;
  assign in_accept = in_valid && !in_stall;
  assign s1_fire   = s1_valid_r && !s1_busy;
  assign out_valid      = out_valid_r;
  assign out_pair_count = out_count_r;

  assign in_code   = letter_code(in_residue);
  assign pair_addr = BIN_BITS'(prev_code_r) * BIN_BITS'(ALPHABET) + BIN_BITS'(in_code);

  always_comb begin
    rd_en         = 1'b0;
    rd_addr       = pair_addr;
    prev_code_nxt = prev_code_r;
    have_prev_nxt = have_prev_r;
    s1_valid_nxt  = s1_busy ? s1_valid_r : 1'b0;
    s1_op_nxt     = s1_op_r;
    s1_addr_nxt   = s1_addr_r;
    if (in_accept) begin
      case (func_t'(in_func))
        FUNC_RESIDUE: begin
          prev_code_nxt = in_code;
          have_prev_nxt = 1'b1;
          if (have_prev_r) begin
            rd_en        = 1'b1;
            s1_valid_nxt = 1'b1;
            s1_op_nxt    = OP_INC;
            s1_addr_nxt  = pair_addr;
          end
        end
        FUNC_READ: begin
          rd_addr      = in_bin_index;
          s1_valid_nxt = 1'b1;
          s1_addr_nxt  = in_bin_index;
          if (in_bin_index < BIN_BITS'(NUM_BINS)) begin
            rd_en     = 1'b1;
            s1_op_nxt = OP_READ;
          end else begin
            s1_op_nxt = OP_READ_OOR;
          end
        end
        FUNC_START: begin
          prev_code_nxt = '0;
          have_prev_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cur_count = (fwd_valid_r && fwd_addr_r == s1_addr_r) ? fwd_data_r : rd_data;
    cur_ext   = EXT_BITS'(cur_count);
    s1_we     = 1'b0;
    s1_wdata  = '0;
    out_valid_nxt = out_valid_r && out_stall;
    out_count_nxt = out_count_r;
    if (s1_fire) begin
      case (s1_op_r)
        OP_INC: begin
          s1_we    = 1'b1;
          s1_wdata = (&cur_count) ? cur_count : cur_count + COUNT_BITS'(1);
        end
        OP_READ: begin
          s1_we         = 1'b1;
          out_valid_nxt = 1'b1;
          out_count_nxt = cur_ext[PAIR_COUNT_BITS-1:0];
        end
        OP_READ_OOR: begin
          out_valid_nxt = 1'b1;
          out_count_nxt = '0;
        end
        default: begin
        end
      endcase
    end
    fwd_valid_nxt = fwd_valid_r || s1_we;
    fwd_addr_nxt  = s1_we ? s1_addr_r : fwd_addr_r;
    fwd_data_nxt  = s1_we ? s1_wdata : fwd_data_r;
  end

  always_comb begin
    clearing_nxt = clearing_r;
    clr_addr_nxt = clr_addr_r;
    if (clearing_r) begin
      clr_addr_nxt = clr_addr_r + BIN_BITS'(1);
      if (clr_addr_r == BIN_BITS'(NUM_BINS - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
    ram_we    = clearing_r || s1_we;
    ram_waddr = clearing_r ? clr_addr_r : s1_addr_r;
    ram_wdata = clearing_r ? '0 : s1_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      prev_code_r <= '0;
      have_prev_r <= 1'b0;
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clearing_r  <= clearing_nxt;
      clr_addr_r  <= clr_addr_nxt;
      prev_code_r <= prev_code_nxt;
      have_prev_r <= have_prev_nxt;
      s1_valid_r  <= s1_valid_nxt;
      fwd_valid_r <= fwd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r     <= s1_op_nxt;
    s1_addr_r   <= s1_addr_nxt;
    fwd_addr_r  <= fwd_addr_nxt;
    fwd_data_r  <= fwd_data_nxt;
    out_count_r <= out_count_nxt;
  end

  dph_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(NUM_BINS)
  ) u_bins (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

endmodule

`default_nettype wire

@@ hw/rtl/dph_checker.sv @@
// Port-level checker for the dipeptide pair histogram and its bind.
`default_nettype none

`include "dipeptide_pair_histogram_assert.svh"

module dph_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_valid,
  input wire logic                                in_stall,
  input wire logic [dph_pkg::FUNC_BITS-1:0]       in_func,
  input wire logic                                out_valid,
  input wire logic                                out_stall,
  input wire logic [dph_pkg::PAIR_COUNT_BITS-1:0] out_pair_count
);

  import dph_pkg::*;

  logic read_accept;

  assign read_accept = in_valid && !in_stall && (in_func == FUNC_READ);

  `DPH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                   out_valid && $stable(out_pair_count), "Stalled result transaction changed.")

  `DPH_ASSERT_NOW(a_clear_after_reset, clk, rst_n, !$past(rst_n), in_stall,
                  "Input accepted while the bin memory is still being cleared.")

  `DPH_ASSERT_NOW(a_result_from_read, clk, rst_n, $rose(out_valid), $past(read_accept, 2),
                  "Result transaction without a read transaction two cycles earlier.")

endmodule

bind dipeptide_pair_histogram dph_checker u_dph_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_func       (in_func),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_pair_count(out_pair_count)
);

`default_nettype wire

@@ test/tb_dipeptide_pair_histogram.sv @@
// Self-checking testbench for the dipeptide pair histogram with random flow control.
`timescale 1ns / 100ps

module tb_dipeptide_pair_histogram;
  import dph_pkg::*;

  localparam int HIST_COUNT_BITS = 16;
  localparam logic [HIST_COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;
  localparam string AMINO_LETTERS = "ACDEFGHIKLMNPQRSTVWY";
  localparam int RANDOM_ITEMS = 450;
  localparam int REPEAT_RUN = 30;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int LONG_HOLD_AFTER = 60;
  localparam int SETTLE_CYCLES = 10;
  localparam longint TIMEOUT_NS = 64'd2_000_000;

  typedef struct {
    bit                      drain;
    logic [FUNC_BITS-1:0]    func;
    logic [RESIDUE_BITS-1:0] residue;
    logic [BIN_BITS-1:0]     bin_index;
  } hist_item_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [FUNC_BITS-1:0] in_func = '0;
  logic [RESIDUE_BITS-1:0] in_residue = '0;
  logic [BIN_BITS-1:0] in_bin_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PAIR_COUNT_BITS-1:0] out_pair_count;

  hist_item_t pending_items[$];
  hist_item_t cur_item;
  logic [PAIR_COUNT_BITS-1:0] expected_counts[$];

  logic [HIST_COUNT_BITS-1:0] bin_store [NUM_BINS];
  logic [CODE_BITS-1:0] last_code;
  bit have_last;

  int error_count = 0;
  int accepted_count = 0;
  int results_seen = 0;
  int nonzero_reads = 0;
  int out_of_range_reads = 0;
  int saturated_reads = 0;
  int input_stall_cycles = 0;
  int burst_left = 1;
  int gap_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int stall_pct = 0;
  int mode_left = 0;

  dipeptide_pair_histogram #(
    .COUNT_BITS(HIST_COUNT_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_func(in_func),
    .in_residue(in_residue),
    .in_bin_index(in_bin_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_pair_count(out_pair_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d counts still outstanding", expected_counts.size());
    $display("FAILURE");
    $finish;
  end

  function automatic logic [CODE_BITS-1:0] residue_code(input logic [RESIDUE_BITS-1:0] ch);
    logic [CODE_BITS-1:0] code;
    code = '0;
    for (int i = 0; i < ALPHABET; i++) begin
      if (AMINO_LETTERS[i] == ch) begin
        code = CODE_BITS'(i);
      end
    end
    return code;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic apply_to_histogram(input hist_item_t item);
    logic [CODE_BITS-1:0] code;
    int idx;
    case (item.func)
      FUNC_RESIDUE: begin
        code = residue_code(item.residue);
        if (have_last) begin
          idx = int'(last_code) * ALPHABET + int'(code);
          if (bin_store[idx] != COUNT_MAX) begin
            bin_store[idx] = bin_store[idx] + 1'b1;
          end
        end
        last_code = code;
        have_last = 1'b1;
      end
      FUNC_READ: begin
        if (int'(item.bin_index) < NUM_BINS) begin
          expected_counts.push_back(PAIR_COUNT_BITS'(bin_store[item.bin_index]));
          bin_store[item.bin_index] = '0;
        end else begin
          expected_counts.push_back('0);
          out_of_range_reads++;
        end
      end
      FUNC_START: begin
        have_last = 1'b0;
        last_code = '0;
      end
      default: begin
      end
    endcase
  endtask

  task automatic add_item(input logic [FUNC_BITS-1:0] func, input logic [RESIDUE_BITS-1:0] ch,
                          input logic [BIN_BITS-1:0] idx);
    hist_item_t item;
    item.drain = 1'b0;
    item.func = func;
    item.residue = ch;
    item.bin_index = idx;
    pending_items.push_back(item);
  endtask

  task automatic add_residue(input logic [RESIDUE_BITS-1:0] ch);
    add_item(FUNC_RESIDUE, ch, BIN_BITS'($urandom_range(0, 511)));
  endtask

  task automatic add_read(input logic [BIN_BITS-1:0] idx);
    add_item(FUNC_READ, RESIDUE_BITS'($urandom_range(0, 255)), idx);
  endtask

  task automatic add_start();
    add_item(FUNC_START, RESIDUE_BITS'($urandom_range(0, 255)),
             BIN_BITS'($urandom_range(0, 511)));
  endtask

  task automatic add_drain();
    hist_item_t item;
    item.drain = 1'b1;
    item.func = FUNC_UNUSED;
    item.residue = '0;
    item.bin_index = '0;
    pending_items.push_back(item);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_stall) begin
        input_stall_cycles++;
      end
      if (in_valid && !in_stall) begin
        apply_to_histogram(cur_item);
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0 && pending_items[0].drain) begin
          in_valid <= 1'b0;
          if (expected_counts.size() == 0) begin
            void'(pending_items.pop_front());
          end
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          in_valid <= 1'b1;
          in_func <= cur_item.func;
          in_residue <= cur_item.residue;
          in_bin_index <= cur_item.bin_index;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    logic [PAIR_COUNT_BITS-1:0] want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_counts.size() == 0) begin
          report_mismatch($sformatf("unexpected result, pair_count %0d", out_pair_count));
        end else begin
          want = expected_counts.pop_front();
          if (out_pair_count !== want) begin
            report_mismatch($sformatf("result %0d: pair_count %0d, expected %0d",
                                      results_seen, out_pair_count, want));
          end
          if (want != 0) begin
            nonzero_reads++;
          end
          if (want == PAIR_COUNT_BITS'(COUNT_MAX)) begin
            saturated_reads++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && results_seen >= LONG_HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        if (mode_left <= 0) begin
          mode_left = $urandom_range(20, 80);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 60;
            default: stall_pct = 90;
          endcase
        end
        mode_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  initial begin
    int random_items;
    int seq_len;
    int reads;
    int k;
    logic [RESIDUE_BITS-1:0] ch;
    logic [RESIDUE_BITS-1:0] subset [3];
    bit use_subset;
    logic [CODE_BITS-1:0] seq_codes[$];

    for (int i = 0; i < NUM_BINS; i++) begin
      bin_store[i] = '0;
    end
    last_code = '0;
    have_last = 1'b0;

    // Lowercase and non-letter bytes all fold onto code zero.
    add_residue("A");
    add_residue("Y");
    add_residue("a");
    add_residue(8'h00);
    add_residue(8'hFF);
    add_item(FUNC_UNUSED, 8'hFF, 9'h1FF);
    add_read(9'd19);
    add_read(9'd380);
    add_read(9'd0);
    add_read(9'd0);
    add_read(9'd399);
    add_read(9'd400);
    add_read(9'h1FF);
    add_start();
    add_residue("W");
    add_residue("Y");
    add_residue("Y");
    add_start();
    add_residue("Y");
    add_read(9'd379);
    add_read(9'd399);
    add_drain();

    add_start();
    for (int i = 0; i < REPEAT_RUN; i++) begin
      add_residue("C");
    end
    add_read(9'd21);
    add_read(9'd21);
    add_drain();

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) != 0) begin
        add_start();
        seq_codes.delete();
        random_items++;
      end
      use_subset = ($urandom_range(0, 1) == 0);
      for (int i = 0; i < 3; i++) begin
        subset[i] = AMINO_LETTERS[$urandom_range(0, ALPHABET - 1)];
      end
      seq_len = $urandom_range(2, 20);
      for (int i = 0; i < seq_len; i++) begin
        if ($urandom_range(0, 15) == 0) begin
          ch = RESIDUE_BITS'($urandom_range(0, 255));
        end else if (use_subset) begin
          ch = subset[$urandom_range(0, 2)];
        end else begin
          ch = AMINO_LETTERS[$urandom_range(0, ALPHABET - 1)];
        end
        add_residue(ch);
        seq_codes.push_back(residue_code(ch));
        random_items++;
      end
      reads = $urandom_range(0, 4);
      for (int r = 0; r < reads; r++) begin
        k = $urandom_range(0, 99);
        if (k < 60 && seq_codes.size() >= 2) begin
          k = (r == 0) ? seq_codes.size() - 2 : $urandom_range(0, seq_codes.size() - 2);
          add_read(BIN_BITS'(int'(seq_codes[k]) * ALPHABET + int'(seq_codes[k + 1])));
        end else if (k < 85) begin
          add_read(BIN_BITS'($urandom_range(0, NUM_BINS - 1)));
        end else begin
          add_read(BIN_BITS'($urandom_range(NUM_BINS, 511)));
        end
        random_items++;
      end
      if ($urandom_range(0, 7) == 0) begin
        add_item(FUNC_UNUSED, RESIDUE_BITS'($urandom_range(0, 255)),
                 BIN_BITS'($urandom_range(0, 511)));
      end
      if ($urandom_range(0, 29) == 0) begin
        add_drain();
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_valid) begin
      @(posedge clk);
    end
    while (expected_counts.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d transactions, checked %0d bin reads (%0d nonzero, %0d saturated, %0d %s).",
             accepted_count, results_seen, nonzero_reads, saturated_reads,
             out_of_range_reads, "out of range");
    $display("Input was held off for %0d cycles; %0d mismatches found.",
             input_stall_cycles, error_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
